>>> sv/tcl_pkg.sv
// Shared types, constants and helpers for the text console display writer.
// No dependencies; every other file in sv/ imports this package.
package tcl_pkg;

    // Default geometry of the text store
    localparam int ROWS_DEF    = 4;
    localparam int COLUMNS_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Display row address commands
    localparam logic [7:0] ADDR_ROW0 = 8'h80;
    localparam logic [7:0] ADDR_ROW1 = 8'h90;
    localparam logic [7:0] ADDR_ROW2 = 8'h88;
    localparam logic [7:0] ADDR_ROW3 = 8'h98;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCROLL,
        S_SCROLL_END,
        S_STORE,
        S_REF_INIT,
        S_REFRESH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // take the input item and update the cursor
        logic scroll_step;  // copy one entry up by one row
        logic scroll_end;   // blank the last row
        logic store;        // write the character at the cursor
        logic ref_init;     // rewind the refresh counters
        logic ref_run;      // stream refresh writes into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic do_store;
        logic do_scroll;
        logic do_refresh;
        logic scroll_last;  // final copy read issued this cycle
        logic ref_done;     // final refresh write loaded this cycle
    } t_sts;

    // Address command for a display row
    function automatic logic [7:0] row_cmd(input logic [1:0] row);
        logic [7:0] res;
        unique case (row)
            2'd0:    res = ADDR_ROW0;
            2'd1:    res = ADDR_ROW1;
            2'd2:    res = ADDR_ROW2;
            default: res = ADDR_ROW3;
        endcase
        return res;
    endfunction

endpackage

>>> sv/text_console_to_lcd_writes_core.sv
// Top level of the text console display writer: controller plus datapath.
// Depends on tcl_pkg, tcl_ctrl and tcl_dpath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | i_valid / o_stall  | i_char_in[7:0]
//   output  | out       | o_valid / i_stall  | o_is_data, o_bus_byte[7:0], o_last
//
// An ignored character passes through the idle and check states, a stored one
// also through the store state, and a newline goes from check to its refresh.
// A scroll copies (ROWS-1)*COLUMNS entries up by one row, one entry per cycle
// through the single write port of the text store, then blanks the last row.
// A refresh has a setup state, then (ROWS-1)*(COLUMNS+1) writes, one per cycle
// while the output is not stalled; a stall holds the sequence where it is.
// On reset, per-entry valid bits make the store read as spaces.
module text_console_to_lcd_writes_core import tcl_pkg::*; #(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_data,
    output logic [7:0] o_bus_byte,
    output logic       o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequence the work for each item
    tcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold the text and drive the display writes
    tcl_dpath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_in  (i_char_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_is_data  (o_is_data),
        .o_bus_byte (o_bus_byte),
        .o_last     (o_last)
    );

endmodule

>>> sv/tcl_ctrl.sv
// Controller state machine of the text console display writer.
// Depends on tcl_pkg (state enum, command and status structs).
module tcl_ctrl import tcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.do_scroll)       n_state = S_SCROLL;
                else if (i_sts.do_store)   n_state = S_STORE;
                else if (i_sts.do_refresh) n_state = S_REF_INIT;
                else                       n_state = S_IDLE;
            end
            S_SCROLL: begin
                if (i_sts.scroll_last) n_state = S_SCROLL_END;
            end
            S_SCROLL_END: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                n_state = i_sts.do_refresh ? S_REF_INIT : S_IDLE;
            end
            S_REF_INIT: begin
                n_state = S_REFRESH;
            end
            S_REFRESH: begin
                if (i_sts.ref_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_SCROLL:     o_cmd.scroll_step = 1'b1;
            S_SCROLL_END: o_cmd.scroll_end  = 1'b1;
            S_STORE:      o_cmd.store       = 1'b1;
            S_REF_INIT:   o_cmd.ref_init    = 1'b1;
            S_REFRESH:    o_cmd.ref_run     = 1'b1;
            default:      o_cmd             = '0;
        endcase
    end

    // A scroll always ends with the character store
    a_scroll_then_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCROLL_END |=> r_state == S_STORE)
        else $error("scroll did not continue into the store");

    // Items are only taken while idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> r_state == S_IDLE && !o_stall)
        else $error("item accepted outside idle");

    // The final refresh write returns the controller to idle
    a_refresh_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REFRESH && i_sts.ref_done |=> r_state == S_IDLE)
        else $error("refresh did not return to idle");

endmodule

>>> sv/tcl_dpath.sv
// Datapath of the text console display writer: cursor, text store memory,
// scroll copy, refresh sequencing and output register. Depends on tcl_pkg.
module tcl_dpath import tcl_pkg::*; #(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char_in,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_stall,
    output logic       o_valid,
    output logic       o_is_data,
    output logic [7:0] o_bus_byte,
    output logic       o_last
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int POS_W  = $clog2(COLUMNS + 1);
    localparam int COPY_N = (ROWS - 1) * COLUMNS;

    // Cursor and item registers
    logic [7:0]       r_char;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_crow, n_crow;
    logic             r_do_store, n_do_store;
    logic             r_do_scroll, n_do_scroll;
    logic             r_do_refresh, n_do_refresh;
    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] row_adv;

    // Memory and scroll copy
    logic [7:0]        r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid, n_valid;
    logic [7:0]        r_rd_data;
    logic              r_rd_valid;
    logic [7:0]        rd_resolved;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] store_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] r_scnt;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_wr_pend;

    // Refresh sequencing
    logic [ROW_W-1:0]  r_rrow;
    logic [POS_W-1:0]  r_pos;
    logic [ADDR_W-1:0] r_rptr, n_rptr;
    logic              out_load;
    logic              ref_last;
    logic              pos_data;
    logic              r_out_valid;
    logic              r_is_data;
    logic [7:0]        r_bus_byte;
    logic              r_last;

    // Work out the cursor move for the offered character
    always_comb begin
        col_inc      = {1'b0, r_col} + 1'b1;
        wrap         = col_inc >= (COL_W + 1)'(COLUMNS);
        row_inc      = (r_crow < ROW_W'(ROWS)) ? r_crow + 1'b1 : r_crow;
        row_adv      = r_crow;
        n_col        = r_col;
        n_crow       = r_crow;
        n_do_store   = 1'b0;
        n_do_scroll  = 1'b0;
        n_do_refresh = 1'b0;
        case (i_char_in) inside
            CH_NEWLINE: begin
                n_col        = '0;
                n_crow       = row_inc;
                n_do_refresh = 1'b1;
            end
            CH_RETURN, CH_NUL: begin
                n_col = r_col;
            end
            default: begin
                n_col        = wrap ? '0 : col_inc[COL_W-1:0];
                row_adv      = wrap ? row_inc : r_crow;
                n_do_store   = 1'b1;
                n_do_refresh = wrap;
                if (row_adv == ROW_W'(ROWS)) begin
                    n_crow      = ROW_W'(ROWS - 1);
                    n_do_scroll = 1'b1;
                end else begin
                    n_crow = row_adv;
                end
            end
        endcase
    end

    // Take the item and advance the cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_crow       <= '0;
            r_do_store   <= 1'b0;
            r_do_scroll  <= 1'b0;
            r_do_refresh <= 1'b0;
        end else if (i_cmd.accept) begin
            r_col        <= n_col;
            r_crow       <= n_crow;
            r_do_store   <= n_do_store;
            r_do_scroll  <= n_do_scroll;
            r_do_refresh <= n_do_refresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_char <= i_char_in;
    end

    // Step the scroll copy: read one row below, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt    <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.scroll_step;
            if (i_cmd.accept) begin
                r_scnt <= '0;
            end else if (i_cmd.scroll_step) begin
                r_scnt <= r_scnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_step) r_wr_addr <= r_scnt;
    end

    // Select the memory ports
    assign store_addr  = ADDR_W'(r_crow) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign rd_resolved = r_rd_valid ? r_rd_data : CH_SPACE;
    assign wr_en       = r_wr_pend || i_cmd.store;
    assign wr_addr     = r_wr_pend ? r_wr_addr : store_addr;
    assign wr_data     = r_wr_pend ? rd_resolved : r_char;
    assign rd_addr     = i_cmd.scroll_step ? r_scnt + ADDR_W'(COLUMNS) : n_rptr;

    // Text store memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd_data <= r_mem[rd_addr];
    end

    // Entry valid bits: an entry never written reads as a space
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.scroll_end) n_valid[DEPTH-1 -: COLUMNS] = '0;
        if (wr_en)            n_valid[wr_addr] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            r_valid    <= n_valid;
        end
    end

    // Refresh sequencing: position 0 is the row command, then the row's bytes
    assign out_load = i_cmd.ref_run && (!r_out_valid || !i_stall);
    assign pos_data = r_pos != '0;
    assign ref_last = (r_rrow == ROW_W'(ROWS - 2)) && (r_pos == POS_W'(COLUMNS));
    assign n_rptr   = (out_load && pos_data) ? r_rptr + 1'b1 : r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rrow <= '0;
            r_pos  <= '0;
            r_rptr <= '0;
        end else if (i_cmd.ref_init) begin
            r_rrow <= '0;
            r_pos  <= '0;
            r_rptr <= '0;
        end else if (out_load) begin
            r_rptr <= n_rptr;
            if (r_pos == POS_W'(COLUMNS)) begin
                r_pos  <= '0;
                r_rrow <= r_rrow + 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Output register: load when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_is_data  <= pos_data;
            r_bus_byte <= pos_data ? rd_resolved : row_cmd(2'(r_rrow));
            r_last     <= ref_last;
        end
    end

    // Status and ports
    always_comb begin
        o_sts.do_store    = r_do_store;
        o_sts.do_scroll   = r_do_scroll;
        o_sts.do_refresh  = r_do_refresh;
        o_sts.scroll_last = i_cmd.scroll_step && (r_scnt == ADDR_W'(COPY_N - 1));
        o_sts.ref_done    = out_load && ref_last;
    end

    assign o_valid    = r_out_valid;
    assign o_is_data  = r_is_data;
    assign o_bus_byte = r_bus_byte;
    assign o_last     = r_last;

    // Cursor row stays within range
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crow <= ROW_W'(ROWS))
        else $error("cursor row out of range");

    // A character lands on a displayable row
    a_store_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> r_crow < ROW_W'(ROWS) && !r_wr_pend)
        else $error("store row out of range or port collision");

    // The last row is blank right after a scroll
    a_last_row_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scroll_end |=> r_valid[DEPTH-1 -: COLUMNS] == '0)
        else $error("last row not cleared by scroll");

    // The final scroll copy is still pending when the scroll ends
    a_scroll_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scroll_end |-> r_wr_pend)
        else $error("scroll ended without final copy");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_to_lcd_writes_core: predicts the writes per item.
// Depends on tcl_pkg and the core RTL; a queue-fed driver and a clocked monitor.
module tb_top;
    import tcl_pkg::*;

    localparam int ROWS         = ROWS_DEF;
    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int RANDOM_ITEMS = 350;
    localparam int TAIL_ITEMS   = 40;
    localparam int HOLD_AFTER   = 40;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_write;

    typedef struct packed {
        logic [7:0] ch;
        logic       wait_drain;
    } t_char_item;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_char_in = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_is_data;
    logic [7:0] o_bus_byte;
    logic       o_last;

    // Console shadow state
    logic [7:0]  screen [ROWS*COLUMNS];
    int unsigned cur_col;
    int unsigned cur_row;

    t_char_item  chars_to_send [$];
    t_lcd_write  lcd_writes_due [$];
    int unsigned chars_accepted = 0;
    int unsigned mismatches     = 0;

    // Pacing state for both sides
    bit          tail_calm      = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned send_phase_cnt = 0;
    int unsigned send_rate      = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned recv_phase_cnt = 0;
    int unsigned recv_rate      = 0;

    text_console_to_lcd_writes_core #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_in  (i_char_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_data  (o_is_data),
        .o_bus_byte (o_bus_byte),
        .o_last     (o_last)
    );

    // Apply one accepted character to the shadow console and queue the writes it causes
    task automatic console_apply(input logic [7:0] ch);
        logic       refresh_now;
        logic [7:0] row_addr;
        refresh_now = 1'b0;
        if (ch == CH_NEWLINE) begin
            if (cur_row < ROWS) cur_row++;
            cur_col     = 0;
            refresh_now = 1'b1;
        end else if (ch != CH_RETURN && ch != CH_NUL) begin
            // advance the column first, wrapping into the next row
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                if (cur_row < ROWS) cur_row++;
                refresh_now = 1'b1;
            end
            // scroll up when the cursor has dropped below the last row
            if (cur_row >= ROWS) begin
                for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen[i] = screen[i+COLUMNS];
                for (int i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++) screen[i] = CH_SPACE;
                cur_row = ROWS - 1;
            end
            screen[cur_row*COLUMNS + cur_col] = ch;
        end
        if (refresh_now) begin
            // last row is never sent
            for (int r = 0; r < ROWS-1; r++) begin
                case (r)
                    0:       row_addr = ADDR_ROW0;
                    1:       row_addr = ADDR_ROW1;
                    2:       row_addr = ADDR_ROW2;
                    default: row_addr = ADDR_ROW3;
                endcase
                lcd_writes_due.push_back({1'b0, row_addr, 1'b0});
                for (int c = 0; c < COLUMNS; c++)
                    lcd_writes_due.push_back({1'b1, screen[r*COLUMNS + c],
                                              (r == ROWS-2 && c == COLUMNS-1) ? 1'b1 : 1'b0});
            end
        end
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic wait_drain);
        chars_to_send.push_back({ch, wait_drain});
    endtask

    // Sender: present items from the pending queue with random gaps
    always @(posedge i_clk) begin : sender
        logic       offer_next;
        logic [7:0] char_next;
        t_char_item item;
        offer_next = i_valid;
        char_next  = i_char_in;
        if (!i_rst_n) begin
            offer_next = 1'b0;
            char_next  = CH_NUL;
        end else begin
            // take the accepted item into the prediction
            if (i_valid && !o_stall) begin
                console_apply(i_char_in);
                chars_accepted++;
                offer_next = 1'b0;
            end
            if (send_phase_cnt == 0) begin
                send_phase_cnt = $urandom_range(100, 300);
                send_rate      = $urandom_range(0, 3);
            end else begin
                send_phase_cnt--;
            end
            // offer the next item unless a gap or a drain pause holds it
            if (!offer_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (chars_to_send.size() > 0 &&
                             !(chars_to_send[0].wait_drain && lcd_writes_due.size() != 0)) begin
                    item       = chars_to_send.pop_front();
                    char_next  = item.ch;
                    offer_next = 1'b1;
                    if (!tail_calm && hold_left == 0 && $urandom_range(0, 3) < send_rate)
                        send_gap = $urandom_range(1, 13);
                end
            end
            tail_calm = chars_to_send.size() < TAIL_ITEMS;
        end
        i_valid   <= offer_next;
        i_char_in <= char_next;
    end

    // Monitor: check each accepted write and drive the receiver stall
    always @(posedge i_clk) begin : receiver
        t_lcd_write got;
        t_lcd_write want;
        logic       stall_next;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_is_data, o_bus_byte, o_last};
                if (lcd_writes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected write is_data=%0d byte=%02h last=%0d",
                             $realtime, got.is_data, got.bus_byte, got.last);
                end else begin
                    want = lcd_writes_due.pop_front();
                    if (got.is_data !== want.is_data || got.bus_byte !== want.bus_byte ||
                        got.last !== want.last) begin
                        mismatches++;
                        $display({"%0t: write mismatch: expected is_data=%0d byte=%02h ",
                                  "last=%0d, got is_data=%0d byte=%02h last=%0d"},
                                 $realtime, want.is_data, want.bus_byte, want.last,
                                 got.is_data, got.bus_byte, got.last);
                    end
                end
            end
            if (recv_phase_cnt == 0) begin
                recv_phase_cnt = $urandom_range(100, 300);
                recv_rate      = $urandom_range(0, 3);
            end else begin
                recv_phase_cnt--;
            end
            // one long hold-off early on so the block backs up
            if (!hold_done && chars_accepted >= HOLD_AFTER) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (!tail_calm && $urandom_range(0, 7) < recv_rate) begin
                stall_left = $urandom_range(1, 13) - 1;
                stall_next = 1'b1;
            end
        end
        i_stall <= stall_next;
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned pick;
        int unsigned burst;
        logic [7:0]  ch;
        logic        drain;

        for (int i = 0; i < ROWS*COLUMNS; i++) screen[i] = CH_SPACE;
        cur_col = 0;
        cur_row = 0;

        // Directed: ignored bytes, a plain store, newlines up to and past the last row
        queue_char(CH_NUL, 1'b0);
        queue_char(CH_RETURN, 1'b0);
        queue_char(8'h41, 1'b0);
        repeat (5) queue_char(CH_NEWLINE, 1'b0);
        // printable below the last row scrolls
        queue_char(8'h5A, 1'b0);
        // fill the row with field extremes; the final one wraps below the last row
        queue_char(8'hFF, 1'b0);
        queue_char(8'h01, 1'b0);
        queue_char(8'h7F, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char(8'h09, 1'b0);
        queue_char(8'h0B, 1'b0);
        queue_char(8'h0C, 1'b0);
        queue_char(8'h0E, 1'b0);
        queue_char(8'hFE, 1'b0);
        queue_char(8'h20, 1'b0);
        queue_char(8'hAA, 1'b0);
        queue_char(8'h55, 1'b0);
        queue_char(8'hC3, 1'b0);
        queue_char(8'h3C, 1'b0);
        queue_char(8'h7E, 1'b0);

        // Random text: mostly printable, some newlines and bursts of them, a few ignored bytes
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            drain = (counted == 0 || counted == 120 || counted == 260);
            pick  = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_char(pick[0] ? CH_RETURN : CH_NUL, drain);
            end else if (pick < 11) begin
                queue_char(CH_NEWLINE, drain);
                counted++;
            end else if (pick == 11) begin
                burst = $urandom_range(3, 6);
                repeat (burst) queue_char(CH_NEWLINE, drain);
                counted += burst;
            end else begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_NUL || ch == CH_NEWLINE || ch == CH_RETURN) ch ^= 8'h40;
                queue_char(ch, drain);
                counted++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain everything, then allow the longest scroll plus refresh to settle
        while (chars_to_send.size() != 0 || i_valid || lcd_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
